@@ hdl/fatc_pkg.sv @@
// ============================================================================
// fatc_pkg
// Shared constants and types for the FAT16 contiguous chain table block.
// ============================================================================
package fatc_pkg;

    // volume geometry
    localparam int MAX_FILES          = 4;
    localparam int FAT_SECTORS        = 125;
    localparam int ENTRIES_PER_SECTOR = 256;
    localparam int SIZE_REGS          = 4;
    localparam int CLUSTER_BYTES      = 512;
    localparam int COUNT_LIMIT        = (MAX_FILES < SIZE_REGS) ? MAX_FILES : SIZE_REGS;

    // field widths
    localparam int SECTOR_W  = 7;
    localparam int ENTRY_W   = $clog2(ENTRIES_PER_SECTOR);
    localparam int FATE_W    = 16;
    localparam int COUNT_W   = 3;
    localparam int SIZE_W    = 23;
    localparam int CIDX_W    = 3;
    localparam int EIDX_W    = SECTOR_W + ENTRY_W;
    localparam int CLUS_SH   = $clog2(CLUSTER_BYTES);
    localparam int CLUS_W    = SIZE_W + 1 - CLUS_SH;
    localparam int SUM_W     = CLUS_W + $clog2(SIZE_REGS);
    localparam int IN_DATA_W = 16;

    // register indexes of the configuration port
    localparam logic [CIDX_W-1:0] CFG_FILE_COUNT  = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_FILE_SIZE_0 = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_FILE_SIZE_1 = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_FILE_SIZE_2 = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_FILE_SIZE_3 = 3'd4;

    // fixed entry values
    localparam logic [FATE_W-1:0] ENTRY_MEDIA   = 16'hFFF8;
    localparam logic [FATE_W-1:0] ENTRY_EOC     = 16'hFFFF;
    localparam logic [FATE_W-1:0] ENTRY_FREE    = 16'h0000;

    // running cluster sums after each file, last one is the total
    typedef struct packed {
        logic [SIZE_REGS-1:0][SUM_W-1:0] prefix;
    } t_chain_info;

endpackage

@@ hdl/fatc_cfg.sv @@
// ============================================================================
// fatc_cfg
// Configuration registers and the derived per-file cluster prefix sums.
// ============================================================================
module fatc_cfg
    import fatc_pkg::*;
#(
    parameter int P_MAX_FILES = MAX_FILES
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [SIZE_W-1:0] i_cfg_data,
    output t_chain_info       o_chain
);

    // counted files are capped by the file limit and the size registers
    localparam int FILE_LIMIT = (P_MAX_FILES < SIZE_REGS) ? P_MAX_FILES : SIZE_REGS;

    logic [COUNT_W-1:0]                r_file_count;
    logic [SIZE_REGS-1:0][SIZE_W-1:0]  r_file_size;
    logic [SIZE_REGS-1:0][CLUS_W-1:0]  r_clusters;
    logic [SIZE_REGS-1:0][CLUS_W-1:0]  n_clusters;
    logic [SIZE_REGS-1:0][SUM_W-1:0]   r_prefix;
    logic [SIZE_REGS-1:0][SUM_W-1:0]   n_prefix;
    logic [COUNT_W-1:0]                w_counted;
    logic [SIZE_W:0]                   w_round [SIZE_REGS];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_count <= '0;
            r_file_size  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FILE_COUNT:  r_file_count   <= i_cfg_data[COUNT_W-1:0];
                CFG_FILE_SIZE_0: r_file_size[0] <= i_cfg_data;
                CFG_FILE_SIZE_1: r_file_size[1] <= i_cfg_data;
                CFG_FILE_SIZE_2: r_file_size[2] <= i_cfg_data;
                CFG_FILE_SIZE_3: r_file_size[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // files beyond the limit count as absent
    always_comb begin
        if (r_file_count > COUNT_W'(FILE_LIMIT)) begin
            w_counted = COUNT_W'(FILE_LIMIT);
        end else begin
            w_counted = r_file_count;
        end
    end

    // clusters per file, size rounded up to whole clusters, uncounted files zero
    always_comb begin
        for (int k = 0; k < SIZE_REGS; k++) begin
            w_round[k] = {1'b0, r_file_size[k]} + (SIZE_W+1)'(CLUSTER_BYTES - 1);
            if (COUNT_W'(k) < w_counted) begin
                n_clusters[k] = w_round[k][SIZE_W:CLUS_SH];
            end else begin
                n_clusters[k] = '0;
            end
        end
    end

    // running sums over the files
    always_comb begin
        n_prefix[0] = SUM_W'(r_clusters[0]);
        for (int k = 1; k < SIZE_REGS; k++) begin
            n_prefix[k] = n_prefix[k-1] + SUM_W'(r_clusters[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clusters <= '0;
            r_prefix   <= '0;
        end else begin
            r_clusters <= n_clusters;
            r_prefix   <= n_prefix;
        end
    end

    assign o_chain.prefix = r_prefix;

endmodule

@@ hdl/fatc_pipe.sv @@
// ============================================================================
// fatc_pipe
// Four-stage entry pipeline: index, classify, compare, select/output.
// ============================================================================
module fatc_pipe
    import fatc_pkg::*;
#(
    parameter int P_FAT_SECTORS = FAT_SECTORS
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_chain_info         i_chain,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [SECTOR_W-1:0] i_sector_num,
    input  logic [ENTRY_W-1:0]  i_entry_index,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [FATE_W-1:0]   o_fat_entry
);

    // stage valids and ready chain
    logic r_vld_a, r_vld_b, r_vld_c, r_vld_d;
    logic w_rdy_a, w_rdy_b, w_rdy_c, w_rdy_d;

    assign w_rdy_d = !r_vld_d || i_ready;
    assign w_rdy_c = !r_vld_c || w_rdy_d;
    assign w_rdy_b = !r_vld_b || w_rdy_c;
    assign w_rdy_a = !r_vld_a || w_rdy_b;
    assign o_ready = w_rdy_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
        end else begin
            if (w_rdy_a) r_vld_a <= i_valid;
            if (w_rdy_b) r_vld_b <= r_vld_a;
            if (w_rdy_c) r_vld_c <= r_vld_b;
            if (w_rdy_d) r_vld_d <= r_vld_c;
        end
    end

    // stage a: capture the request
    logic [SECTOR_W-1:0] r_sector_a;
    logic [ENTRY_W-1:0]  r_entry_a;

    always_ff @(posedge i_clk) begin
        if (w_rdy_a && i_valid) begin
            r_sector_a <= i_sector_num;
            r_entry_a  <= i_entry_index;
        end
    end

    // stage b: flat entry number and its neighbors
    logic [EIDX_W-1:0] w_e;
    logic [EIDX_W-1:0] r_em1_b;
    logic [FATE_W-1:0] r_ep1_b;
    logic              r_oor_b, r_is0_b, r_is1_b;

    assign w_e = {r_sector_a, r_entry_a};

    always_ff @(posedge i_clk) begin
        if (w_rdy_b && r_vld_a) begin
            r_em1_b <= w_e - EIDX_W'(1);
            r_ep1_b <= FATE_W'(w_e) + FATE_W'(1);
            r_oor_b <= {2'b00, r_sector_a} >= (SECTOR_W+2)'(P_FAT_SECTORS);
            r_is0_b <= (w_e == '0);
            r_is1_b <= (w_e == EIDX_W'(1));
        end
    end

    // stage c: compare against the running cluster sums
    logic              w_hit;
    logic              r_hit_c, r_past_c, r_oor_c, r_is0_c, r_is1_c;
    logic [FATE_W-1:0] r_ep1_c;

    always_comb begin
        w_hit = 1'b0;
        for (int k = 0; k < SIZE_REGS; k++) begin
            if (SUM_W'(r_em1_b) == i_chain.prefix[k]) w_hit = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_c && r_vld_b) begin
            r_hit_c  <= w_hit;
            r_past_c <= SUM_W'(r_em1_b) > i_chain.prefix[SIZE_REGS-1];
            r_oor_c  <= r_oor_b;
            r_is0_c  <= r_is0_b;
            r_is1_c  <= r_is1_b;
            r_ep1_c  <= r_ep1_b;
        end
    end

    // stage d: pick the entry value into the output register
    logic [FATE_W-1:0] w_value;
    logic [FATE_W-1:0] r_entry_d;

    always_comb begin
        if (r_oor_c) begin
            w_value = ENTRY_FREE;
        end else if (r_is0_c) begin
            w_value = ENTRY_MEDIA;
        end else if (r_is1_c) begin
            w_value = ENTRY_EOC;
        end else if (r_past_c) begin
            w_value = ENTRY_FREE;
        end else if (r_hit_c) begin
            w_value = ENTRY_EOC;
        end else begin
            w_value = r_ep1_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_d && r_vld_c) begin
            r_entry_d <= w_value;
        end
    end

    assign o_valid     = r_vld_d;
    assign o_fat_entry = r_entry_d;

endmodule

@@ hdl/fat16_contiguous_chain_table.sv @@
// ============================================================================
// fat16_contiguous_chain_table
// FAT16 entry generator for a read-only volume of back-to-back files.
// ============================================================================
// four register stages (a, b, c, d); o_m_axis_tvalid is the valid of the last stage
// one beat per cycle unless i_m_axis_tready stalls, set by the four-stage entry pipeline
// configuration reaches the compare stage through the size, cluster and prefix registers
// synchronous active-low reset clears config and valid registers and empties the pipeline
// ============================================================================
module fat16_contiguous_chain_table
    import fatc_pkg::*;
#(
    parameter int P_MAX_FILES   = MAX_FILES,
    parameter int P_FAT_SECTORS = FAT_SECTORS
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [IN_DATA_W-1:0] i_s_axis_tdata,  // sector_num[6:0], entry_index[14:7], pad
    // result stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [FATE_W-1:0]    o_m_axis_tdata,  // fat_entry[15:0]
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CIDX_W-1:0]    i_cfg_idx,
    input  logic [SIZE_W-1:0]    i_cfg_data
);

    t_chain_info w_chain;

    // configuration and cluster sums
    fatc_cfg #(
        .P_MAX_FILES (P_MAX_FILES)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_chain    (w_chain)
    );

    // entry pipeline
    fatc_pipe #(
        .P_FAT_SECTORS (P_FAT_SECTORS)
    ) u_pipe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_chain       (w_chain),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_sector_num  (i_s_axis_tdata[SECTOR_W-1:0]),
        .i_entry_index (i_s_axis_tdata[SECTOR_W+ENTRY_W-1:SECTOR_W]),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_fat_entry   (o_m_axis_tdata)
    );

endmodule
